// ===== rtl/scenc_pkg.sv =====
// shared types and constants for the sin/cos encoder angle and speed core
// no dependencies
package scenc_pkg;

	typedef struct packed {
		logic [15:0] sin_code;
		logic [15:0] cos_code;
		logic [19:0] step_time_us;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        angle_bam;
		logic signed [23:0] speed_q8;
		logic [1:0]         status;
	} out_item_t;

	// normalised pair waiting between front and back
	typedef struct packed {
		logic signed [15:0] sin_n;
		logic signed [15:0] cos_n;
		logic [19:0]        dt;
	} norm_item_t;

	localparam logic [1:0] CFG_CENTER = 2'd0;
	localparam logic [1:0] CFG_GAIN   = 2'd1;

	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_FIRST   = 2'd1;
	localparam logic [1:0] ST_ZERO_DT = 2'd2;

	localparam logic [15:0] CENTER_RESET = 16'd32768;
	localparam logic [23:0] GAIN_RESET   = 24'd65536;
	localparam logic [24:0] NORM_LIMIT   = 25'd19661;
	// 2*pi*1e6/256 in q16
	localparam logic [30:0] SPEED_K_Q16  = 31'd1608495439;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// round half up from q16 product, clamp to 1.2, apply sign
	function automatic logic signed [15:0] norm_round(input logic [40:0] prod, input logic neg);
		logic [40:0] sum;
		logic [24:0] q;
		logic [15:0] m;
		sum = prod + 41'd32768;
		q = sum[40:16];
		if (q > NORM_LIMIT) begin
			q = NORM_LIMIT;
		end
		m = q[15:0];
		return neg ? -$signed(m) : $signed(m);
	endfunction

endpackage

// ===== rtl/scenc_fifo.sv =====
// two-entry queue between the front and the back
// no package dependencies
module scenc_fifo #(
	parameter int W = 52
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule

// ===== rtl/scenc_front.sv =====
// front: takes an item, centres and scales both codes with one shared multiplier
// depends on scenc_pkg
module scenc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  scenc_pkg::in_item_t   in_data,
	input  logic [15:0]           center,
	input  logic [23:0]           gain,
	output logic                  push,
	output scenc_pkg::norm_item_t push_data,
	input  logic                  full
);
	import scenc_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MS   = 4'b0010,
		F_MC   = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t       state_q;
	in_item_t           item_q;
	logic [40:0]        prod_q;
	logic               neg_q;
	logic signed [15:0] sin_n_q;

	logic [15:0]        code;
	logic signed [16:0] centred;
	logic [16:0]        mag;
	logic [40:0]        prod;

	assign code    = (state_q == F_MS) ? item_q.sin_code : item_q.cos_code;
	assign centred = $signed({1'b0, code}) - $signed({1'b0, center});
	assign mag     = centred[16] ? 17'(-centred) : 17'(centred);
	assign prod    = 41'(mag) * 41'(gain);

	assign in_stall  = state_q != F_IDLE;
	assign push      = state_q == F_PUSH;
	assign push_data = '{sin_n: sin_n_q, cos_n: norm_round(prod_q, neg_q),
		dt: item_q.step_time_us};

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == F_MS || state_q == F_MC) begin
			prod_q <= prod;
			neg_q  <= centred[16];
		end
		if (state_q == F_MC) begin
			sin_n_q <= norm_round(prod_q, neg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_MS;
				F_MS:   state_q <= F_MC;
				F_MC:   state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/scenc_back.sv =====
// back: cordic atan2, angle step, serial speed divide, result register
// depends on scenc_pkg
module scenc_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  scenc_pkg::norm_item_t pop_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output scenc_pkg::out_item_t  out_data
);
	import scenc_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

	typedef enum logic [5:0] {
		B_IDLE   = 6'b000001,
		B_CORDIC = 6'b000010,
		B_MUL    = 6'b000100,
		B_PRE    = 6'b001000,
		B_DIV    = 6'b010000,
		B_DONE   = 6'b100000
	} back_state_t;

	back_state_t        state_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [31:0]        z_q;
	logic [IW-1:0]      i_q;
	logic               zero_q;
	logic [19:0]        dt_q;
	logic [15:0]        ang_q;
	logic               dneg_q;
	logic [1:0]         status_q;
	logic [47:0]        prod_q;
	logic [31:0]        div_q;
	logic [19:0]        rem_q;
	logic [4:0]         cnt_q;
	logic [15:0]        prev_q;
	logic               prev_valid_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [31:0] x0;
	logic signed [31:0] y0;
	logic signed [31:0] xs;
	logic signed [31:0] ys;
	logic [31:0]        at;
	logic [15:0]        ang;
	logic [15:0]        delta;
	logic [16:0]        dmag;
	logic [47:0]        num;
	logic [20:0]        trial;
	logic               fits;
	logic signed [23:0] speed;
	logic               out_free;

	assign pop      = state_q == B_IDLE && !empty;
	assign out_free = !out_valid_q || !out_stall;

	assign x0 = 32'(pop_data.cos_n) <<< 8;
	assign y0 = 32'(pop_data.sin_n) <<< 8;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_turn(5'(i_q));

	// round the turn accumulator to 16 bits, wrapping
	assign ang   = zero_q ? 16'd0 : z_q[31:16] + 16'(z_q[15]);
	assign delta = ang - prev_q;
	assign dmag  = delta[15] ? 17'(-$signed({1'b1, delta})) : {1'b0, delta};

	assign num   = prod_q + {13'd0, dt_q, 15'd0};
	assign trial = {rem_q, div_q[31]};
	assign fits  = trial >= {1'b0, dt_q};

	always_comb begin
		speed = '0;
		if (status_q == ST_VALID) begin
			if (dneg_q) begin
				speed = (div_q > 32'd8388608) ? 24'sh800000 : -$signed(div_q[23:0]);
			end else begin
				speed = (div_q > 32'd8388607) ? 24'sh7FFFFF : $signed(div_q[23:0]);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					zero_q <= pop_data.sin_n == 16'sd0 && pop_data.cos_n == 16'sd0;
					dt_q   <= pop_data.dt;
					i_q    <= '0;
					if (pop_data.cos_n < 0) begin
						x_q <= -x0;
						y_q <= -y0;
						z_q <= 32'h80000000;
					end else begin
						x_q <= x0;
						y_q <= y0;
						z_q <= 32'h0;
					end
				end
			end
			B_CORDIC: begin
				if (!y_q[31]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
				i_q <= i_q + IW'(1);
			end
			B_MUL: begin
				ang_q  <= ang;
				dneg_q <= delta[15];
				prod_q <= 48'(dmag) * 48'(SPEED_K_Q16);
				if (dt_q == 20'd0) begin
					status_q <= ST_ZERO_DT;
				end else if (!prev_valid_q) begin
					status_q <= ST_FIRST;
				end else begin
					status_q <= ST_VALID;
				end
			end
			B_PRE: begin
				// half divisor for rounding, then drop the q16 scale of the dividend
				div_q <= num[47:16];
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				rem_q <= fits ? 20'(trial - {1'b0, dt_q}) : trial[19:0];
				div_q <= {div_q[30:0], fits};
				cnt_q <= cnt_q + 5'd1;
			end
			B_DONE: begin
				if (out_free) begin
					out_q <= '{angle_bam: ang_q, speed_q8: speed, status: status_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// a result stays until taken; a new one is loaded only when the register is free
			out_valid_q <= (state_q == B_DONE && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				B_IDLE:   if (!empty) state_q <= B_CORDIC;
				B_CORDIC: if (i_q == LAST_STEP) state_q <= B_MUL;
				B_MUL: begin
					if (dt_q != 20'd0) begin
						prev_q       <= ang;
						prev_valid_q <= 1'b1;
					end
					state_q <= (dt_q != 20'd0 && prev_valid_q) ? B_PRE : B_DONE;
				end
				B_PRE:    state_q <= B_DIV;
				B_DIV:    if (cnt_q == 5'd31) state_q <= B_DONE;
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/sincos_encoder_angle_and_speed_core.sv =====
// Sin/cos encoder angle and speed core. Each item is a raw sine and cosine
// code pair with the microseconds since the last pair; each gives one result
// item with a 16-bit angle, a saturated speed in rad/s times 256 and a status.
// The front takes a new item only after pushing the last one and normalises
// both codes on one multiplier; a two-entry queue holds normalised pairs for
// the back. The back sets the sustained rate: the angle takes a load state,
// CORDIC_STEPS CORDIC steps and a multiply state, then a valid speed takes a
// set-up state and the one-bit-per-cycle divider; first-pair and zero-step
// items skip the divide. A finished result waits in the output register while
// the next item is worked on.
// depends on scenc_pkg, scenc_front, scenc_fifo, scenc_back
module sincos_encoder_angle_and_speed_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  scenc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output scenc_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import scenc_pkg::*;

	logic [15:0] center_q;
	logic [23:0] gain_q;
	logic        push;
	norm_item_t  push_data;
	logic        full;
	logic        pop;
	norm_item_t  pop_data;
	logic        empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CENTER) begin
				center_q <= cfg_data[15:0];
			end
			if (cfg_index == CFG_GAIN) begin
				gain_q <= cfg_data;
			end
		end
	end

	scenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.center    (center_q),
		.gain      (gain_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	scenc_fifo #(
		.W ($bits(norm_item_t))
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	scenc_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_VALID || out_data.status == ST_FIRST ||
			out_data.status == ST_ZERO_DT))
		else $error("bad status code");

	a_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_VALID |-> out_data.speed_q8 == 24'sd0)
		else $error("speed set without a valid step");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |=> !empty)
		else $error("queue lost an item");
endmodule
